// ===== sv/nma_pkg.sv =====
// Package: widths, register indexes, span type and clash check for the match accumulator.
package nma_pkg;
  localparam int MaxMatches = 64;
  localparam int IdxW = $clog2(MaxMatches);
  localparam int CntW = IdxW + 1;
  localparam int CoordBits = 16;

  typedef enum logic {
    CFG_MARGIN = 1'b0,
    CFG_THRESH = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CoordBits-1:0] qs;
    logic [CoordBits-1:0] qe;
    logic [CoordBits-1:0] ts;
    logic [CoordBits-1:0] te;
  } span_t;

  // Return 1 when a kept span clashes with the new one under margin o.
  function automatic logic spans_clash(span_t nw, span_t kp, logic [7:0] o);
    logic signed [CoordBits+1:0] nqs, nqe, nts, nte, kqs, kqe, kts, kte, om;
    logic c;
    begin
      nqs = {2'b00, nw.qs}; nqe = {2'b00, nw.qe};
      nts = {2'b00, nw.ts}; nte = {2'b00, nw.te};
      kqs = {2'b00, kp.qs}; kqe = {2'b00, kp.qe};
      kts = {2'b00, kp.ts}; kte = {2'b00, kp.te};
      om = {{(CoordBits-6){1'b0}}, o};
      c = 1'b0;
      if (kqs >= nqs && kqs < nqe - om) c = 1'b1;
      if (kqe > nqs + om && kqe <= nqe) c = 1'b1;
      if (kts >= nts && kts < nte - om) c = 1'b1;
      if (kte > nts + om && kte <= nte) c = 1'b1;
      if (kqs <= nqs && kqe >= nqe) c = 1'b1;
      if (kts <= nts && kte >= nte) c = 1'b1;
      return c;
    end
  endfunction
endpackage

// ===== sv/nma_divider.sv =====
// Restoring divider: 37-bit numerator over 22-bit denominator, one bit a cycle.
module nma_divider import nma_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [36:0] num_i,
  input  logic [21:0] den_i,
  output logic        done_o,
  output logic [13:0] quo_o
);
  logic [36:0] num_q, num_d, quo_q, quo_d;
  logic [22:0] rem_q, rem_d;
  logic [21:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [22:0] shl;

  // Shift in one numerator bit and try a subtract.
  always_comb begin
    num_d = num_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    shl = {rem_q[21:0], num_q[36]};
    if (start_i) begin
      num_d = num_i; den_d = den_i; rem_d = '0; quo_d = '0;
      cnt_d = 6'd37; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[35:0], 1'b0};
      if (shl >= {1'b0, den_q}) begin
        rem_d = shl - {1'b0, den_q};
        quo_d = {quo_q[35:0], 1'b1};
      end else begin
        rem_d = shl;
        quo_d = {quo_q[35:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  // Saturate the quotient to the field.
  assign quo_o = (|quo_q[36:14]) ? 14'h3FFF : quo_q[13:0];
endmodule

// ===== sv/nma_span_ram.sv =====
// Span table memory: one write port, one registered read port.
module nma_span_ram import nma_pkg::*; (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  span_t           wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output span_t           rdata_o
);
  span_t mem [MaxMatches];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== sv/nonoverlap_match_accumulator_top.sv =====
// Top level: match overlap scan over the span table, accumulators, output register.
//
// Usage: present match records on the in channel (valid/ready); each record
// yields exactly one result on the out channel. Configuration writes go over
// the cfg channel (index 0 overlap margin, index 1 underflow threshold) and
// are taken only while the block is idle.
// Sequence: a record is compared against the kept spans one entry per cycle
// through the span memory's read port; on the last record of a pair the
// average identity is then formed by a bit-serial divider.
// Flow: one record at a time; the next one is taken once the result is
// in the output register, while that result waits.
// Reset: all sums and the kept count clear, margin returns to 1 and the
// threshold to 9040; the span memory holds no reset and needs none, since
// only entries below the kept count are read.
// Stall: a result waits in the output register as long as out_ready_i is low;
// a following record is processed and then holds until that register is free.
module nonoverlap_match_accumulator_top import nma_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [13:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               new_pair_i,
  input  logic               last_of_pair_i,
  input  logic [15:0]        query_start_i,
  input  logic [15:0]        query_end_i,
  input  logic [15:0]        target_start_i,
  input  logic [15:0]        target_end_i,
  input  logic [15:0]        match_length_i,
  input  logic [13:0]        identity_pct_i,
  input  logic [15:0]        match_score_i,
  input  logic signed [14:0] neglog_e_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o,
  output logic               table_full_o,
  output logic [6:0]         kept_count_o,
  output logic [15:0]        total_count_o,
  output logic [23:0]        sum_score_o,
  output logic [21:0]        sum_length_o,
  output logic [13:0]        avg_identity_o,
  output logic signed [14:0] best_neglog_e_o,
  output logic signed [20:0] sum_neglog_e_o,
  output logic               best_e_zero_o,
  output logic               prod_e_zero_o,
  output logic               pair_done_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_UPD, S_DIV, S_OUT
  } state_e;

  state_e state_q;
  logic [7:0]  margin_q;
  logic [13:0] thresh_q;
  logic [CntW-1:0] kept_q;
  logic [15:0] seen_q;
  logic [23:0] score_q;
  logic [21:0] len_q;
  logic [36:0] wid_q;
  logic signed [14:0] best_q;
  logic signed [20:0] esum_q;

  // Held record.
  span_t nw_q;
  logic last_q;
  logic [15:0] rlen_q, rsc_q;
  logic [13:0] ridp_q;
  logic signed [14:0] re_q;
  logic [CntW-1:0] ptr_q;  // next address to read
  logic [CntW-1:0] cmp_q;  // entries compared so far
  logic rdv_q, clash_q, acc_q, full_q;

  span_t rdata;
  logic  div_done;
  logic [13:0] div_quo;
  logic  div_start;
  logic [36:0] div_num;
  logic [21:0] div_den;

  logic in_fire, out_fire, out_load;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign out_load = (state_q == S_OUT) && (!out_valid_o || out_ready_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= 8'd1;
      thresh_q <= 14'd9040;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MARGIN: margin_q <= cfg_data_i[7:0];
        CFG_THRESH: thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Span memory; appended at kept_q on acceptance.
  logic ram_we;
  assign ram_we = (state_q == S_UPD) && !clash_q && (kept_q < CntW'(MaxMatches));
  nma_span_ram u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(kept_q[IdxW-1:0]), .wdata_i(nw_q),
    .raddr_i(ptr_q[IdxW-1:0]), .rdata_o(rdata)
  );

  // Accumulator next values.
  logic [24:0] score_n;
  logic [22:0] len_n;
  logic [37:0] wid_n;
  logic [29:0] prod_q;
  logic signed [21:0] esum_n;
  assign score_n = {1'b0, score_q} + 25'(rsc_q);
  assign len_n   = {1'b0, len_q} + 23'(rlen_q);
  assign wid_n   = {1'b0, wid_q} + 38'(prod_q);
  assign esum_n  = 22'(esum_q) + 22'(re_q);

  // Values after this record's update, used to start the divider.
  assign div_num = ram_we ? (wid_n[37] ? {37{1'b1}} : wid_n[36:0]) : wid_q;
  assign div_den = ram_we ? (len_n[22] ? {22{1'b1}} : len_n[21:0]) : len_q;

  assign div_start = (state_q == S_UPD) && last_q;
  nma_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .done_o(div_done), .quo_o(div_quo)
  );

  // Control and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kept_q <= '0; seen_q <= '0; score_q <= '0; len_q <= '0;
      wid_q <= '0; best_q <= '0; esum_q <= '0;
      out_valid_o <= 1'b0;
      ptr_q <= '0; cmp_q <= '0; rdv_q <= 1'b0; clash_q <= 1'b0;
      acc_q <= 1'b0; full_q <= 1'b0;
    end else begin
      if (out_load) out_valid_o <= 1'b1;
      else if (out_fire) out_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (new_pair_i) begin
              kept_q <= '0; score_q <= '0; len_q <= '0;
              wid_q <= '0; best_q <= '0; esum_q <= '0;
              seen_q <= 16'd1;
            end else if (seen_q != 16'hFFFF) begin
              seen_q <= seen_q + 16'd1;
            end
            ptr_q <= '0; cmp_q <= '0; rdv_q <= 1'b0; clash_q <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Issue one read a cycle while entries remain and no clash is seen; check returned data.
          rdv_q <= 1'b0;
          if (!clash_q && ptr_q < kept_q) begin
            ptr_q <= ptr_q + 1'b1;
            rdv_q <= 1'b1;
          end
          if (rdv_q) begin
            cmp_q <= cmp_q + 1'b1;
            if (spans_clash(nw_q, rdata, margin_q)) clash_q <= 1'b1;
          end
          if (clash_q || (cmp_q == kept_q && !rdv_q)) state_q <= S_UPD;
        end
        S_UPD: begin
          acc_q <= ram_we;
          full_q <= !clash_q && !ram_we;
          if (ram_we) begin
            score_q <= score_n[24] ? 24'hFFFFFF : score_n[23:0];
            len_q <= len_n[22] ? 22'h3FFFFF : len_n[21:0];
            wid_q <= wid_n[37] ? {37{1'b1}} : wid_n[36:0];
            if (kept_q == '0 || re_q > best_q) best_q <= re_q;
            if (esum_n > 22'sd1048575) esum_q <= 21'sd1048575;
            else if (esum_n < -22'sd1048576) esum_q <= -21'sd1048576;
            else esum_q <= esum_n[20:0];
            kept_q <= kept_q + 1'b1;
          end
          state_q <= last_q ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_done) state_q <= S_OUT;
        end
        S_OUT: begin
          // Hold until the output register is free.
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Record hold and product register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      nw_q <= '{qs: query_start_i, qe: query_end_i, ts: target_start_i, te: target_end_i};
      last_q <= last_of_pair_i;
      rlen_q <= match_length_i; rsc_q <= match_score_i;
      ridp_q <= identity_pct_i; re_q <= neglog_e_i;
    end
    prod_q <= rlen_q * 30'(ridp_q);
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      accepted_o <= acc_q;
      table_full_o <= full_q;
      kept_count_o <= 7'(kept_q);
      total_count_o <= seen_q;
      sum_score_o <= score_q;
      sum_length_o <= len_q;
      avg_identity_o <= (last_q && len_q != '0) ? div_quo : 14'd0;
      best_neglog_e_o <= best_q;
      sum_neglog_e_o <= esum_q;
      best_e_zero_o <= last_q && (best_q >= $signed({1'b0, thresh_q}));
      prod_e_zero_o <= last_q && (esum_q >= $signed({7'd0, thresh_q}));
      pair_done_o <= last_q;
    end
  end

`ifndef ASSERT_OFF
  // Kept count never exceeds the table depth.
  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= CntW'(MaxMatches)) else $error("kept count overflow");
  // Accept and full are exclusive in a result.
  a_acc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(accepted_o && table_full_o)) else $error("accept and full");
  // No write to the table while scanning it.
  a_no_wr_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> !ram_we) else $error("write during scan");
  // Divider finishes only while waiting for it.
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("stray divider done");
`endif
endmodule
